// ===== src/fcs_pkg.sv =====
`default_nettype none

package fcs_pkg;

	localparam int COORD_BITS  = 9;
	localparam int RAD_BITS    = 7;
	localparam int COLOR_BITS  = 16;
	localparam int ERR_BITS    = 11;
	localparam int MAX_RESULTS = 64;
	localparam int N_BITS      = $clog2(MAX_RESULTS + 1);
	localparam int PC_BITS     = 2;
	localparam int UCODE_DEPTH = 1 << PC_BITS;

	localparam logic [COORD_BITS-1:0] ACTIVE_RESET = COORD_BITS'(240);

	// configuration register indexes
	localparam logic REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic REG_ACTIVE_HEIGHT = 1'b1;

	// microprogram addresses
	localparam logic [PC_BITS-1:0] PC_WAIT  = PC_BITS'(0);
	localparam logic [PC_BITS-1:0] PC_INIT  = PC_BITS'(1);
	localparam logic [PC_BITS-1:0] PC_SPAN  = PC_BITS'(2);
	localparam logic [PC_BITS-1:0] PC_SPARE = PC_BITS'(3);

	typedef struct packed {
		logic [COORD_BITS-1:0] center_x;
		logic [COORD_BITS-1:0] center_y;
		logic [RAD_BITS-1:0]   radius;
		logic [COLOR_BITS-1:0] color;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] near_row_below;
		logic [COORD_BITS-1:0] near_row_above;
		logic [COORD_BITS-1:0] near_start;
		logic [COORD_BITS-1:0] near_width;
		logic [COORD_BITS-1:0] far_row_below;
		logic [COORD_BITS-1:0] far_row_above;
		logic [COORD_BITS-1:0] far_start;
		logic [COORD_BITS-1:0] far_width;
		logic [3:0]            span_valid;
		logic [COLOR_BITS-1:0] span_color;
		logic                  last;
	} out_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] row_below;
		logic [COORD_BITS-1:0] row_above;
		logic [COORD_BITS-1:0] start;
		logic [COORD_BITS-1:0] width;
		logic [1:0]            valid;
	} pair_t;

	// datapath controls from the microword
	typedef struct packed {
		logic in_rdy;
		logic init;
		logic emit;
	} ctl_t;

	// datapath status back to the sequencer
	typedef struct packed {
		logic in_fire;
		logic emit_fire;
		logic last_fire;
	} stat_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_IN,
		COND_LAST
	} cond_t;

	typedef struct packed {
		ctl_t                ctl;
		cond_t               cond;
		logic [PC_BITS-1:0]  target;
	} uword_t;

	// step: take a circle, set up the loop, then one span result per step while the output is not stalled
	localparam uword_t UCODE [UCODE_DEPTH] = '{
		'{ctl: '{in_rdy: 1'b1, init: 1'b0, emit: 1'b0}, cond: COND_IN,     target: PC_INIT},
		'{ctl: '{in_rdy: 1'b0, init: 1'b1, emit: 1'b0}, cond: COND_ALWAYS, target: PC_SPAN},
		'{ctl: '{in_rdy: 1'b0, init: 1'b0, emit: 1'b1}, cond: COND_LAST,   target: PC_WAIT},
		'{ctl: '{in_rdy: 1'b0, init: 1'b0, emit: 1'b0}, cond: COND_ALWAYS, target: PC_WAIT}
	};

endpackage

`default_nettype wire

// ===== src/fcs_pair.sv =====
`default_nettype none

module fcs_pair import fcs_pkg::*; (
	input  wire logic [COORD_BITS-1:0] cx,
	input  wire logic [COORD_BITS-1:0] cy,
	input  wire logic [RAD_BITS-1:0]   d,
	input  wire logic [RAD_BITS-1:0]   h,
	input  wire logic [COORD_BITS-1:0] aw,
	input  wire logic [COORD_BITS-1:0] ah,
	output pair_t                      pair
);

	logic [COORD_BITS-1:0] hx, dx, start, wfull, above;
	logic [COORD_BITS:0]   span_end, below;
	logic                  on_x, vb, va;

	always_comb begin
		hx       = COORD_BITS'(h);
		dx       = COORD_BITS'(d);
		start    = (cx > hx) ? cx - hx : '0;
		wfull    = COORD_BITS'({h, 1'b1});
		span_end = {1'b0, start} + {1'b0, wfull};
		on_x     = start < aw;
		below    = {1'b0, cy} + {1'b0, dx};
		above    = cy - dx;
		vb       = on_x && (below < {1'b0, ah});
		va       = on_x && (cy >= dx) && (above < ah);

		pair.start     = start;
		pair.row_below = vb ? below[COORD_BITS-1:0] : '0;
		pair.row_above = va ? above : '0;
		pair.valid     = {va, vb};
		if (!on_x) begin
			pair.width = '0;
		end else if (span_end > {1'b0, aw}) begin
			pair.width = aw - start;
		end else begin
			pair.width = wfull;
		end
	end

endmodule

`default_nettype wire

// ===== src/fcs_ucode.sv =====
`default_nettype none

module fcs_ucode import fcs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t st,
	output ctl_t       ctl
);

	logic [PC_BITS-1:0] pc_q;
	uword_t             uw;
	logic               take;

	always_comb begin
		uw = UCODE[pc_q];
		case (uw.cond)
			COND_ALWAYS: take = 1'b1;
			COND_IN:     take = st.in_fire;
			COND_LAST:   take = st.last_fire;
			default:     take = 1'b0;
		endcase
	end

	assign ctl = uw.ctl;

	// no jump means the step repeats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else if (take) begin
			pc_q <= uw.target;
		end
	end

endmodule

`default_nettype wire

// ===== src/fcs_dpath.sv =====
`default_nettype none

module fcs_dpath import fcs_pkg::*; #(
	parameter int MAX_RADIUS = 85
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctl_t                  ctl,
	output stat_t                      st,
	input  wire logic [COORD_BITS-1:0] aw,
	input  wire logic [COORD_BITS-1:0] ah,
	input  wire logic                  in_valid,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data
);

	localparam logic [RAD_BITS-1:0] RMAX = RAD_BITS'(MAX_RADIUS);

	in_item_t                    in_q;
	logic [RAD_BITS-1:0]         x_q, y_q;
	logic signed [ERR_BITS-1:0]  err_q;
	logic [N_BITS-1:0]           n_q;
	logic                        out_valid_q;
	out_item_t                   out_q;

	logic [RAD_BITS-1:0]         r_sat, y1, x1;
	logic signed [RAD_BITS:0]    dif;
	logic signed [ERR_BITS-1:0]  err1, inc_a, inc_b;
	logic [N_BITS-1:0]           n1;
	logic                        dec, last, emit_fire;
	pair_t                       near_p, far_p;
	out_item_t                   res;

	fcs_pair u_near (
		.cx(in_q.center_x), .cy(in_q.center_y), .d(y_q), .h(x_q),
		.aw(aw), .ah(ah), .pair(near_p)
	);

	fcs_pair u_far (
		.cx(in_q.center_x), .cy(in_q.center_y), .d(x_q), .h(y_q),
		.aw(aw), .ah(ah), .pair(far_p)
	);

	always_comb begin
		r_sat = (in_q.radius > RMAX) ? RMAX : in_q.radius;
		dec   = !err_q[ERR_BITS-1];
		y1    = y_q + RAD_BITS'(1);
		x1    = dec ? x_q - RAD_BITS'(1) : x_q;
		dif   = $signed({1'b0, y1}) - $signed({1'b0, x1});
		inc_a = ERR_BITS'({y1, 1'b1});
		inc_b = ERR_BITS'(signed'({dif, 1'b1}));
		err1  = err_q + (dec ? inc_b : inc_a);
		n1    = n_q + N_BITS'(1);
		// x1 < y1 (x - 1 < y + 1 when x steps) written without going negative
		last  = (dec ? ({1'b0, x_q} < {1'b0, y_q} + (RAD_BITS + 1)'(2))
		             : ({1'b0, x_q} < {1'b0, y_q} + (RAD_BITS + 1)'(1)))
		        || (n1 >= N_BITS'(MAX_RESULTS));

		res.near_row_below = near_p.row_below;
		res.near_row_above = near_p.row_above;
		res.near_start     = near_p.start;
		res.near_width     = near_p.width;
		res.far_row_below  = far_p.row_below;
		res.far_row_above  = far_p.row_above;
		res.far_start      = far_p.start;
		res.far_width      = far_p.width;
		res.span_valid     = {far_p.valid, near_p.valid};
		res.span_color     = in_q.color;
		res.last           = last;
	end

	assign emit_fire    = ctl.emit && (!out_valid_q || !out_stall);
	assign st.in_fire   = ctl.in_rdy && in_valid;
	assign st.emit_fire = emit_fire;
	assign st.last_fire = emit_fire && last;

	always_ff @(posedge clk) begin
		if (st.in_fire) begin
			in_q <= in_data;
		end
		if (ctl.init) begin
			x_q   <= r_sat;
			y_q   <= '0;
			err_q <= ERR_BITS'(1) - ERR_BITS'(r_sat);
			n_q   <= '0;
		end else if (emit_fire) begin
			x_q   <= x1;
			y_q   <= y1;
			err_q <= err1;
			n_q   <= n1;
		end
		if (emit_fire) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== src/filled_circle_span_generator_unit.sv =====
// Filled circle span generator.
// Input channel (in_valid / in_stall / in_data): one circle per beat, with
// center, radius and fill color. Output channel (out_valid / out_stall /
// out_data): one beat per midpoint loop step, holding the near span pair
// (rows center_y +/- y, half-width x) and the far pair (rows center_y +/- x,
// half-width y), a 4-bit valid mask, the color and a last flag on the final
// beat of the circle. A radius above MAX_RADIUS is taken as MAX_RADIUS.
// Configuration: cfg_we / cfg_idx / cfg_data write active_width (index 0)
// or active_height (index 1); write only while idle.
// Timing: a circle is taken, the next cycle sets up the loop, and the loop
// then issues one beat per cycle while the output is not stalled, about
// radius/sqrt(2) + 1 beats (at most 64). Each beat is registered in the
// output register before it appears; the steps are run by the microcoded
// sequencer. One circle is in work at a time.
// A stall on the output holds the current beat and freezes the loop; the
// input stays stalled until the last beat of the circle has been issued.
// Reset: sequencer waits for input, output empty, both sizes back to 240.
`default_nettype none

module filled_circle_span_generator_unit import fcs_pkg::*; #(
	parameter int MAX_RADIUS = 85
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_idx,
	input  wire logic [COORD_BITS-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data
);

	logic [COORD_BITS-1:0] aw_q, ah_q;
	ctl_t                  ctl;
	stat_t                 st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= ACTIVE_RESET;
			ah_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ACTIVE_WIDTH:  aw_q <= cfg_data;
				REG_ACTIVE_HEIGHT: ah_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fcs_ucode u_ucode (
		.clk(clk), .arst_n(arst_n), .st(st), .ctl(ctl)
	);

	fcs_dpath #(.MAX_RADIUS(MAX_RADIUS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .st(st),
		.aw(aw_q), .ah(ah_q),
		.in_valid(in_valid), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	assign in_stall = !ctl.in_rdy;

	// a taken circle blocks the input while its spans are generated
	a_in_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// after the last beat is issued the sequencer returns to waiting
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		st.last_fire |=> !in_stall)
		else $error("input not released after last span");

	// a new beat only appears from an emitting step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.emit))
		else $error("output beat without emit step");

	// results are never issued while an input is being taken
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		st.emit_fire |-> in_stall)
		else $error("emit overlaps input acceptance");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
	import fcs_pkg::*;

	localparam int SAT_RADIUS  = 85;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int IDLE_CYCLES = 4;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic                  cfg_idx = REG_ACTIVE_WIDTH;
	logic [COORD_BITS-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	// screen size as the block should currently see it
	int unsigned scr_width  = 240;
	int unsigned scr_height = 240;

	out_item_t   pending_spans[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned stall_left = 0;
	bit          in_calm = 1'b0;
	bit          out_calm = 1'b0;

	filled_circle_span_generator_unit #(.MAX_RADIUS(SAT_RADIUS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(bit calm);
		int unsigned v;
		if (calm)
			return 0;
		v = $urandom_range(0, 99);
		if (v < 60)
			return 0;
		else if (v < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one span pair: rows cy+d and cy-d, half-width h
	function automatic pair_t span_pair(int cx, int cy, int d, int h);
		pair_t p;
		int    first_col;
		int    span_len;
		int    row_dn;
		bit    on_x;
		first_col = (cx > h) ? cx - h : 0;
		span_len  = 2 * h + 1;
		row_dn    = cy + d;
		on_x      = first_col < int'(scr_width);
		if (on_x) begin
			if (first_col + span_len > int'(scr_width))
				span_len = int'(scr_width) - first_col;
		end else begin
			span_len = 0;
		end
		p.valid[0]  = on_x && row_dn < int'(scr_height);
		p.valid[1]  = on_x && cy >= d && (cy - d) < int'(scr_height);
		p.row_below = p.valid[0] ? COORD_BITS'(row_dn) : '0;
		p.row_above = p.valid[1] ? COORD_BITS'(cy - d) : '0;
		p.start     = COORD_BITS'(first_col);
		p.width     = COORD_BITS'(span_len);
		return p;
	endfunction

	// midpoint loop: one expected beat per step
	function automatic void predict_circle_spans(in_item_t c);
		out_item_t s;
		pair_t     np;
		pair_t     fp;
		int        x;
		int        y;
		int        err;
		int        n;
		x   = (int'(c.radius) > SAT_RADIUS) ? SAT_RADIUS : int'(c.radius);
		y   = 0;
		err = 1 - x;
		n   = 0;
		while (x >= y && n < MAX_RESULTS) begin
			np = span_pair(c.center_x, c.center_y, y, x);
			fp = span_pair(c.center_x, c.center_y, x, y);
			s.near_row_below = np.row_below;
			s.near_row_above = np.row_above;
			s.near_start     = np.start;
			s.near_width     = np.width;
			s.far_row_below  = fp.row_below;
			s.far_row_above  = fp.row_above;
			s.far_start      = fp.start;
			s.far_width      = fp.width;
			s.span_valid     = {fp.valid, np.valid};
			s.span_color     = c.color;
			y++;
			if (err < 0) begin
				err += 2 * y + 1;
			end else begin
				x--;
				err += 2 * (y - x) + 1;
			end
			n++;
			s.last = (x < y) || (n >= MAX_RESULTS);
			pending_spans.push_back(s);
		end
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// output side: check each accepted beat, then pick the next stall
	always @(posedge clk) begin
		out_item_t want;
		int unsigned n;
		if (out_valid && !out_stall) begin
			if (pending_spans.size() == 0) begin
				$error("span beat with nothing expected: %h", out_data);
				mismatch_count++;
			end else begin
				want = pending_spans.pop_front();
				check_field("near_row_below", want.near_row_below, out_data.near_row_below);
				check_field("near_row_above", want.near_row_above, out_data.near_row_above);
				check_field("near_start", want.near_start, out_data.near_start);
				check_field("near_width", want.near_width, out_data.near_width);
				check_field("far_row_below", want.far_row_below, out_data.far_row_below);
				check_field("far_row_above", want.far_row_above, out_data.far_row_above);
				check_field("far_start", want.far_start, out_data.far_start);
				check_field("far_width", want.far_width, out_data.far_width);
				check_field("span_valid", want.span_valid, out_data.span_valid);
				check_field("span_color", want.span_color, out_data.span_color);
				check_field("last", want.last, out_data.last);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			n = pick_gap(out_calm);
			out_stall <= (n > 0);
			if (n > 0)
				stall_left = n - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// valid may be left high for the next circle when no gap is chosen
	task automatic send_circle(int unsigned cx, int unsigned cy, int unsigned r,
			int unsigned col);
		in_item_t    c;
		int unsigned gap;
		c.center_x = COORD_BITS'(cx);
		c.center_y = COORD_BITS'(cy);
		c.radius   = RAD_BITS'(r);
		c.color    = COLOR_BITS'(col);
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_circle_spans(c);
		gap = pick_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_spans();
		in_valid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic idx, int unsigned value);
		drain_spans();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= COORD_BITS'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACTIVE_WIDTH)
			scr_width = value;
		else
			scr_height = value;
	endtask

	task automatic test_reset_sizes();
		send_circle(120, 120, 85, 16'hffff);
		send_circle(0, 0, 0, 16'h0000);
		send_circle(60, 200, 30, 16'h07e0);
	endtask

	task automatic test_screen_edges();
		send_circle(511, 511, 85, 16'hffff);
		send_circle(120, 120, 127, 16'haaaa);   // saturates
		send_circle(120, 120, 86, 16'h5555);
		send_circle(5, 200, 20, 16'hf800);      // start floored at column 0
		send_circle(230, 10, 40, 16'h001f);     // clipped right, rows above 0 dropped
		send_circle(239, 239, 1, 16'h1234);
		send_circle(250, 100, 5, 16'hedcb);     // start past the right edge
	endtask

	task automatic test_clipping();
		write_size(REG_ACTIVE_WIDTH, 511);
		write_size(REG_ACTIVE_HEIGHT, 511);
		send_circle(511, 0, 85, 16'h8001);
		send_circle(0, 511, 64, 16'h7ffe);
		write_size(REG_ACTIVE_WIDTH, 1);
		write_size(REG_ACTIVE_HEIGHT, 1);
		send_circle(0, 0, 3, 16'h0f0f);
		send_circle(1, 0, 2, 16'hf0f0);
		// zero-sized screen: beats still come, all spans dropped
		write_size(REG_ACTIVE_WIDTH, 0);
		write_size(REG_ACTIVE_HEIGHT, 240);
		send_circle(10, 10, 5, 16'h3c3c);
		write_size(REG_ACTIVE_WIDTH, 240);
		write_size(REG_ACTIVE_HEIGHT, 0);
		send_circle(10, 10, 5, 16'hc3c3);
		write_size(REG_ACTIVE_HEIGHT, 240);
	endtask

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 7))
			0: return 1;
			1: return 511;
			2: return 240;
			default: return $urandom_range(1, 511);
		endcase
	endfunction

	task automatic test_random_circles();
		int unsigned v;
		int unsigned r;
		int unsigned cx;
		int unsigned cy;
		for (int phase = 0; phase < 6; phase++) begin
			write_size(REG_ACTIVE_WIDTH, pick_size());
			write_size(REG_ACTIVE_HEIGHT, pick_size());
			in_calm  = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 30; i++) begin
				v = $urandom_range(0, 99);
				if (v < 20)
					r = $urandom_range(0, 8);
				else if (v < 88)
					r = $urandom_range(0, SAT_RADIUS);
				else
					r = $urandom_range(SAT_RADIUS + 1, 127);
				// keep most centers near the visible area
				if ($urandom_range(0, 3) != 0) begin
					cx = $urandom_range(0, (scr_width + 30 > 511) ? 511 : scr_width + 30);
					cy = $urandom_range(0, (scr_height + 30 > 511) ? 511 : scr_height + 30);
				end else begin
					cx = $urandom_range(0, 511);
					cy = $urandom_range(0, 511);
				end
				send_circle(cx, cy, r, $urandom_range(0, 65535));
				if (i == 15)
					drain_spans();
			end
		end
		in_calm  = 1'b0;
		out_calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_sizes();
		test_screen_edges();
		test_clipping();
		test_random_circles();
		drain_spans();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_spans.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
